// ----- sv/msed_pkg.sv -----
// ----------------------------------------------------------------------------
// msed_pkg - shared types, constants and lookup functions
// Character codes, entity progress codes, the entity step table and the
// held-prefix text used by the markup strip / entity decode unit.
// ----------------------------------------------------------------------------
package msed_pkg;

	localparam int ByteW   = 8;
	localparam int ProgW   = 4;
	localparam int MaxRes  = 8;                    // result buffer depth; one byte causes at most seven results
	localparam int CntW    = $clog2(MaxRes + 1);
	localparam int FlushW  = 3;                    // '&' plus at most four held chars

	// character codes
	localparam logic [ByteW-1:0] ChNul   = 8'h00;
	localparam logic [ByteW-1:0] ChSpace = 8'h20;
	localparam logic [ByteW-1:0] ChAmp   = 8'h26;
	localparam logic [ByteW-1:0] ChLt    = 8'h3C;
	localparam logic [ByteW-1:0] ChGt    = 8'h3E;
	localparam logic [ByteW-1:0] ChSemi  = 8'h3B;
	localparam logic [ByteW-1:0] ChQuote = 8'h22;
	localparam logic [ByteW-1:0] ChApos  = 8'h27;
	localparam logic [ByteW-1:0] ChTab   = 8'h09;
	localparam logic [ByteW-1:0] ChCr    = 8'h0D;

	// entity progress: the prefix held after '&'
	localparam logic [ProgW-1:0] ProgNone   = 4'd0;
	localparam logic [ProgW-1:0] ProgHeld   = 4'd1;   // "&" only
	localparam logic [ProgW-1:0] ProgA      = 4'd2;
	localparam logic [ProgW-1:0] ProgAm     = 4'd3;
	localparam logic [ProgW-1:0] ProgAmp    = 4'd4;
	localparam logic [ProgW-1:0] ProgAp     = 4'd5;
	localparam logic [ProgW-1:0] ProgApo    = 4'd6;
	localparam logic [ProgW-1:0] ProgApos   = 4'd7;
	localparam logic [ProgW-1:0] ProgQ      = 4'd8;
	localparam logic [ProgW-1:0] ProgQu     = 4'd9;
	localparam logic [ProgW-1:0] ProgQuo    = 4'd10;
	localparam logic [ProgW-1:0] ProgQuot   = 4'd11;
	localparam logic [ProgW-1:0] ProgHash   = 4'd12;
	localparam logic [ProgW-1:0] ProgHash3  = 4'd13;
	localparam logic [ProgW-1:0] ProgHash39 = 4'd14;
	localparam logic [ProgW-1:0] ProgBad    = 4'd15;  // never produced

	typedef struct packed {
		logic             tag;   // inside <...>
		logic             seen;  // whitespace already folded since last visible char
		logic             pend;  // one space owed before the next visible char
		logic [ProgW-1:0] prog;
	} state_t;

	localparam state_t StateReset = '{tag: 1'b0, seen: 1'b1, pend: 1'b0, prog: ProgNone};

	typedef struct packed {
		logic             hit;   // byte continues the entity
		logic             done;  // byte completes it
		logic [ProgW-1:0] nxt;
		logic [ByteW-1:0] dec;
	} edge_t;

	function automatic logic is_ws(input logic [ByteW-1:0] c);
		is_ws = (c inside {ChSpace, [ChTab:ChCr]});
	endfunction

	function automatic logic prog_held(input logic [ProgW-1:0] p);
		prog_held = (p != ProgNone) && (p != ProgBad);
	endfunction

	// one step of the entity matcher
	function automatic edge_t ent_step(input logic [ProgW-1:0] p, input logic [ByteW-1:0] c);
		edge_t e;
		e = '{hit: 1'b0, done: 1'b0, nxt: ProgNone, dec: ChNul};
		case (p)
			ProgHeld: begin
				if (c == "a")      e = '{1'b1, 1'b0, ProgA, ChNul};
				else if (c == "q") e = '{1'b1, 1'b0, ProgQ, ChNul};
				else if (c == "#") e = '{1'b1, 1'b0, ProgHash, ChNul};
			end
			ProgA: begin
				if (c == "m")      e = '{1'b1, 1'b0, ProgAm, ChNul};
				else if (c == "p") e = '{1'b1, 1'b0, ProgAp, ChNul};
			end
			ProgAm:     if (c == "p")    e = '{1'b1, 1'b0, ProgAmp, ChNul};
			ProgAmp:    if (c == ChSemi) e = '{1'b1, 1'b1, ProgNone, ChAmp};
			ProgAp:     if (c == "o")    e = '{1'b1, 1'b0, ProgApo, ChNul};
			ProgApo:    if (c == "s")    e = '{1'b1, 1'b0, ProgApos, ChNul};
			ProgApos:   if (c == ChSemi) e = '{1'b1, 1'b1, ProgNone, ChApos};
			ProgQ:      if (c == "u")    e = '{1'b1, 1'b0, ProgQu, ChNul};
			ProgQu:     if (c == "o")    e = '{1'b1, 1'b0, ProgQuo, ChNul};
			ProgQuo:    if (c == "t")    e = '{1'b1, 1'b0, ProgQuot, ChNul};
			ProgQuot:   if (c == ChSemi) e = '{1'b1, 1'b1, ProgNone, ChQuote};
			ProgHash:   if (c == "3")    e = '{1'b1, 1'b0, ProgHash3, ChNul};
			ProgHash3:  if (c == "9")    e = '{1'b1, 1'b0, ProgHash39, ChNul};
			ProgHash39: if (c == ChSemi) e = '{1'b1, 1'b1, ProgNone, ChApos};
			default:    e = '{hit: 1'b0, done: 1'b0, nxt: ProgNone, dec: ChNul};
		endcase
		return e;
	endfunction

	// chars released when a held prefix is flushed: '&' then the prefix
	function automatic logic [FlushW-1:0] flush_len(input logic [ProgW-1:0] p);
		logic [FlushW-1:0] n;
		n = '0;
		if (p == ProgHeld)                                     n = 3'd1;
		else if (p inside {ProgA, ProgQ, ProgHash})            n = 3'd2;
		else if (p inside {ProgAm, ProgAp, ProgQu, ProgHash3}) n = 3'd3;
		else if (p inside {ProgAmp, ProgApo, ProgQuo, ProgHash39}) n = 3'd4;
		else if (p inside {ProgApos, ProgQuot})                n = 3'd5;
		return n;
	endfunction

	function automatic logic [ByteW-1:0] flush_char(input logic [ProgW-1:0] p,
	                                                 input logic [FlushW-1:0] i);
		logic [ByteW-1:0] c;
		logic [1:0]       j;
		c = ChAmp;
		j = 2'(i - 3'd1);
		if (i != '0) begin
			if (p inside {ProgA, ProgAm, ProgAmp}) begin
				case (j)
					2'd0:    c = "a";
					2'd1:    c = "m";
					default: c = "p";
				endcase
			end else if (p inside {ProgAp, ProgApo, ProgApos}) begin
				case (j)
					2'd0:    c = "a";
					2'd1:    c = "p";
					2'd2:    c = "o";
					default: c = "s";
				endcase
			end else if (p inside {ProgQ, ProgQu, ProgQuo, ProgQuot}) begin
				case (j)
					2'd0:    c = "q";
					2'd1:    c = "u";
					2'd2:    c = "o";
					default: c = "t";
				endcase
			end else begin
				case (j)
					2'd0:    c = "#";
					2'd1:    c = "3";
					default: c = "9";
				endcase
			end
		end
		return c;
	endfunction

endpackage

// ----- sv/markup_strip_entity_decode_unit.sv -----
// ----------------------------------------------------------------------------
// markup_strip_entity_decode_unit - tag strip, entity decode, space folding
// Cleans a text string one byte per word: drops <...> and stray '>',
// decodes &amp; &quot; &#39; &apos;, folds whitespace runs into one space
// and trims leading and trailing spaces.
// ----------------------------------------------------------------------------
//
//  channel | handshake           | payload
//  --------+---------------------+-----------------------------------------
//  in      | in_valid / in_stall | in_byte[7:0], in_last
//  out     | out_valid/out_stall | out_byte[7:0], has_byte, run_last,
//          |                     | string_end
//
//  Flow: an input word is registered, then decoded combinationally into a
//  result buffer of up to 8 words; a loaded buffer raises out_valid.
//  A byte that releases several results (entity mismatch replay) holds
//  the input while the result buffer drains, one word per cycle when
//  out_stall is low.
//  Reset: arst_n clears the handshake state and the parser state.
//  Stalls: out_stall freezes the result buffer; the input register keeps
//  taking words until a decoded byte finds the buffer still busy.
// ----------------------------------------------------------------------------
module markup_strip_entity_decode_unit (
	input  logic       clk,
	input  logic       arst_n,
	// input channel
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	// result channel
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       has_byte,
	output logic       run_last,
	output logic       string_end
);

	localparam int ByteW  = msed_pkg::ByteW;
	localparam int MaxRes = msed_pkg::MaxRes;
	localparam int CntW   = msed_pkg::CntW;
	localparam int FlushW = msed_pkg::FlushW;

	// ---------------------------------------------------------------- input stage
	logic             valid_s1;
	logic [ByteW-1:0] byte_s1;
	logic             last_s1;

	// ---------------------------------------------------------------- result buffer
	logic [MaxRes-1:0][ByteW-1:0] res_q;
	logic [CntW-1:0]              cnt_q;     // words left to send
	logic                         end_q;     // buffer holds the string's last run
	logic                         has_q;     // 0 only for the bare end marker

	msed_pkg::state_t st_q;

	logic buf_free;
	logic load;
	logic out_take;

	assign out_valid = (cnt_q != '0);
	assign out_take  = out_valid && !out_stall;
	assign buf_free  = (cnt_q == '0) || ((cnt_q == CntW'(1)) && !out_stall);
	assign load      = valid_s1 && buf_free;
	assign in_stall  = valid_s1 && !load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	// ---------------------------------------------------------------- decode
	// Every emitted char goes through the same path: an optional owed space
	// first, then the flushed prefix (on mismatch), then the one plain or
	// decoded char, then an end-of-string flush of whatever prefix is left.
	msed_pkg::edge_t   ed;
	msed_pkg::state_t  st_n;
	logic              pv;          // a prefix is held
	logic              c_match;     // byte continues or ends the entity
	logic              c_done;
	logic              do_plain;    // byte goes through the plain path
	logic              plain_vis;   // plain path emits the byte itself
	logic              plain_ws;
	logic [ByteW-1:0]  mid_char;
	logic [3:0]        prog_a;      // progress after the byte
	logic [FlushW-1:0] len_pre;
	logic              len_mid;
	logic [FlushW-1:0] len_post;
	logic [CntW-1:0]   nvis;
	logic              sp_out;      // owed space goes out first
	logic [CntW-1:0]   off_pre;
	logic [CntW-1:0]   off_mid;
	logic [CntW-1:0]   off_post;
	logic [CntW-1:0]   total;
	logic              bare;
	logic [MaxRes-1:0][ByteW-1:0] res_n;
	logic [CntW-1:0]   cnt_n;
	logic [CntW-1:0]   kk;

	always_comb begin
		ed        = msed_pkg::ent_step(st_q.prog, byte_s1);
		pv        = msed_pkg::prog_held(st_q.prog);
		c_match   = pv && ed.hit;
		c_done    = c_match && ed.done;
		do_plain  = !c_match;
		plain_ws  = do_plain && !st_q.tag && msed_pkg::is_ws(byte_s1);
		plain_vis = do_plain && !st_q.tag && (byte_s1 != msed_pkg::ChLt) &&
		            (byte_s1 != msed_pkg::ChGt) && (byte_s1 != msed_pkg::ChAmp) &&
		            !msed_pkg::is_ws(byte_s1);
		mid_char  = c_done ? ed.dec : byte_s1;

		if (c_match && !c_done)
			prog_a = ed.nxt;
		else if (do_plain && !st_q.tag && (byte_s1 == msed_pkg::ChAmp))
			prog_a = msed_pkg::ProgHeld;
		else
			prog_a = msed_pkg::ProgNone;

		len_pre  = (pv && !ed.hit) ? msed_pkg::flush_len(st_q.prog) : '0;
		len_mid  = c_done || plain_vis;
		len_post = last_s1 ? msed_pkg::flush_len(prog_a) : '0;
		nvis     = CntW'(len_pre) + CntW'(len_mid) + CntW'(len_post);
		sp_out   = st_q.pend && (nvis != '0);
		off_pre  = CntW'(sp_out);
		off_mid  = off_pre + CntW'(len_pre);
		off_post = off_mid + CntW'(len_mid);
		total    = off_post + CntW'(len_post);
		bare     = last_s1 && (total == '0);
		cnt_n    = bare ? CntW'(1) : total;

		for (int k = 0; k < MaxRes; k++) begin
			kk = CntW'(k);
			if (bare)
				res_n[k] = msed_pkg::ChNul;
			else if (kk < off_pre)
				res_n[k] = msed_pkg::ChSpace;
			else if (kk < off_mid)
				res_n[k] = msed_pkg::flush_char(st_q.prog, FlushW'(kk - off_pre));
			else if (kk < off_post)
				res_n[k] = mid_char;
			else
				res_n[k] = msed_pkg::flush_char(prog_a, FlushW'(kk - off_post));
		end

		// parser state, in the order the events happen within the byte
		st_n      = st_q;
		st_n.prog = prog_a;
		if (len_pre != '0) begin
			st_n.seen = 1'b0;
			st_n.pend = 1'b0;
		end
		if (plain_ws && !st_n.seen) begin
			st_n.pend = 1'b1;
			st_n.seen = 1'b1;
		end
		if (len_mid) begin
			st_n.seen = 1'b0;
			st_n.pend = 1'b0;
		end
		if (do_plain && (byte_s1 == msed_pkg::ChLt))
			st_n.tag = 1'b1;
		else if (do_plain && (byte_s1 == msed_pkg::ChGt))
			st_n.tag = 1'b0;
		if (last_s1)
			st_n = msed_pkg::StateReset;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= msed_pkg::StateReset;
			cnt_q <= '0;
			end_q <= 1'b0;
			has_q <= 1'b1;
		end else if (load) begin
			st_q  <= st_n;
			cnt_q <= cnt_n;
			end_q <= last_s1;
			has_q <= !bare;
		end else if (out_take) begin
			cnt_q <= cnt_q - CntW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			res_q <= res_n;
		else if (out_take)
			res_q <= {ByteW'(0), res_q[MaxRes-1:1]};
	end

	assign out_byte   = res_q[0];
	assign has_byte   = has_q;
	assign run_last   = (cnt_q == CntW'(1));
	assign string_end = end_q && (cnt_q == CntW'(1));

	// ---------------------------------------------------------------- checks
	a_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(load && last_s1) |=> (st_q == msed_pkg::StateReset))
		else $error("parser state not back to reset after string end");

	a_prog_code: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.prog != msed_pkg::ProgBad)
		else $error("unused entity progress code reached");

	a_bare_marker: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !has_byte) |-> (run_last && string_end))
		else $error("bare result that is not the string end");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntW'(MaxRes))
		else $error("result count beyond buffer depth");

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid))
		else $error("input stalled with an empty result buffer");

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - testbench for markup_strip_entity_decode_unit
// Drives text strings one byte per word and checks every cleaned result word
// against a behavioral predictor of tag stripping, entity decoding and
// space folding. Both sides idle at random, with full-rate stretches, a long
// output hold and pauses that drain the block.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int ByteW      = msed_pkg::ByteW;
	localparam int ProgW      = msed_pkg::ProgW;
	localparam int MaxRes     = msed_pkg::MaxRes;

	localparam int HalfPeriod = 5;
	localparam int IdlePct    = 24;
	localparam int HoldCycles = 120;    // long output hold, forces input stall
	localparam int TailCycles = 20;     // quiet time after the last result
	localparam int TimeoutNs  = 5_000_000;

	// one result word as the block presents it
	typedef struct packed {
		logic [ByteW-1:0] out_ch;
		logic             has_ch;
		logic             run_end;
		logic             str_end;
	} clean_word_t;

	// entity matcher step: dst ProgBad means the byte breaks the prefix,
	// a nonzero dec means the entity is complete
	typedef struct packed {
		logic [ProgW-1:0] dst;
		logic [ByteW-1:0] dec;
	} ent_move_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_stall;
	logic [7:0] in_byte   = 8'h00;
	logic       in_last   = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_byte;
	logic       has_byte;
	logic       run_last;
	logic       string_end;

	// parser state of the predictor
	logic             st_tag  = 1'b0;
	logic             st_seen = 1'b1;   // leading blanks are swallowed
	logic             st_pend = 1'b0;
	logic [ProgW-1:0] st_prog = msed_pkg::ProgNone;

	logic [ByteW-1:0] rel_q[$];         // chars released by the current word
	clean_word_t      cleaned_q[$];     // result words still owed by the block
	logic [ByteW-1:0] text_q[$];        // string being sent

	int tx_idle_pct = IdlePct;
	int rx_idle_pct = IdlePct;
	int hold_reqs   = 0;                // bumped by a test to ask for a hold
	int hold_served = 0;
	int hold_cnt    = 0;

	int words_sent  = 0;
	int words_in    = 0;
	int results_ok  = 0;
	int strings_end = 0;
	int bare_marks  = 0;
	int err_cnt     = 0;

	markup_strip_entity_decode_unit i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_byte    (in_byte),
		.in_last    (in_last),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.has_byte   (has_byte),
		.run_last   (run_last),
		.string_end (string_end)
	);

	always #HalfPeriod clk = ~clk;

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------
	function automatic void reset_parser();
		st_tag  = 1'b0;
		st_seen = 1'b1;
		st_pend = 1'b0;
		st_prog = msed_pkg::ProgNone;
	endfunction

	function automatic void put_char(input logic [ByteW-1:0] c);
		if (rel_q.size() < MaxRes) rel_q.push_back(c);
	endfunction

	// a visible char first pays any space owed
	function automatic void put_visible(input logic [ByteW-1:0] c);
		if (st_pend) begin
			put_char(msed_pkg::ChSpace);
			st_pend = 1'b0;
		end
		put_char(c);
		st_seen = 1'b0;
	endfunction

	// chars held after the '&' for a given progress code
	function automatic string held_text(input logic [ProgW-1:0] p);
		case (p)
			msed_pkg::ProgA:      return "a";
			msed_pkg::ProgAm:     return "am";
			msed_pkg::ProgAmp:    return "amp";
			msed_pkg::ProgAp:     return "ap";
			msed_pkg::ProgApo:    return "apo";
			msed_pkg::ProgApos:   return "apos";
			msed_pkg::ProgQ:      return "q";
			msed_pkg::ProgQu:     return "qu";
			msed_pkg::ProgQuo:    return "quo";
			msed_pkg::ProgQuot:   return "quot";
			msed_pkg::ProgHash:   return "#";
			msed_pkg::ProgHash3:  return "#3";
			msed_pkg::ProgHash39: return "#39";
			default:              return "";
		endcase
	endfunction

	function automatic ent_move_t entity_move(input logic [ProgW-1:0] p,
	                                          input logic [ByteW-1:0] c);
		ent_move_t m;
		m = '{dst: msed_pkg::ProgNone, dec: msed_pkg::ChNul};
		case (p)
			msed_pkg::ProgHeld:
				m.dst = (c == "a") ? msed_pkg::ProgA :
				        (c == "q") ? msed_pkg::ProgQ :
				        (c == "#") ? msed_pkg::ProgHash : msed_pkg::ProgBad;
			msed_pkg::ProgA:
				m.dst = (c == "m") ? msed_pkg::ProgAm :
				        (c == "p") ? msed_pkg::ProgAp : msed_pkg::ProgBad;
			msed_pkg::ProgAm:
				m.dst = (c == "p") ? msed_pkg::ProgAmp : msed_pkg::ProgBad;
			msed_pkg::ProgAp:
				m.dst = (c == "o") ? msed_pkg::ProgApo : msed_pkg::ProgBad;
			msed_pkg::ProgApo:
				m.dst = (c == "s") ? msed_pkg::ProgApos : msed_pkg::ProgBad;
			msed_pkg::ProgQ:
				m.dst = (c == "u") ? msed_pkg::ProgQu : msed_pkg::ProgBad;
			msed_pkg::ProgQu:
				m.dst = (c == "o") ? msed_pkg::ProgQuo : msed_pkg::ProgBad;
			msed_pkg::ProgQuo:
				m.dst = (c == "t") ? msed_pkg::ProgQuot : msed_pkg::ProgBad;
			msed_pkg::ProgHash:
				m.dst = (c == "3") ? msed_pkg::ProgHash3 : msed_pkg::ProgBad;
			msed_pkg::ProgHash3:
				m.dst = (c == "9") ? msed_pkg::ProgHash39 : msed_pkg::ProgBad;
			msed_pkg::ProgAmp:
				if (c == msed_pkg::ChSemi) m.dec = msed_pkg::ChAmp;
				else m.dst = msed_pkg::ProgBad;
			msed_pkg::ProgApos:
				if (c == msed_pkg::ChSemi) m.dec = msed_pkg::ChApos;
				else m.dst = msed_pkg::ProgBad;
			msed_pkg::ProgQuot:
				if (c == msed_pkg::ChSemi) m.dec = msed_pkg::ChQuote;
				else m.dst = msed_pkg::ProgBad;
			msed_pkg::ProgHash39:
				if (c == msed_pkg::ChSemi) m.dec = msed_pkg::ChApos;
				else m.dst = msed_pkg::ProgBad;
			default:
				m.dst = msed_pkg::ProgBad;
		endcase
		return m;
	endfunction

	// give back a held prefix as plain text: '&' then its chars
	function automatic void flush_held();
		string txt;
		if (st_prog == msed_pkg::ProgNone || st_prog == msed_pkg::ProgBad) begin
			st_prog = msed_pkg::ProgNone;
			return;
		end
		txt = held_text(st_prog);
		put_visible(msed_pkg::ChAmp);
		for (int i = 0; i < txt.len(); i++) put_visible(txt[i]);
		st_prog = msed_pkg::ProgNone;
	endfunction

	function automatic void plain_byte(input logic [ByteW-1:0] c);
		if (c == msed_pkg::ChLt) begin
			st_tag = 1'b1;
		end else if (c == msed_pkg::ChGt) begin
			st_tag = 1'b0;          // closes a tag, or a stray one is dropped
		end else if (!st_tag) begin
			if (c == msed_pkg::ChAmp) begin
				st_prog = msed_pkg::ProgHeld;
			end else if (c == msed_pkg::ChSpace ||
			             (c >= msed_pkg::ChTab && c <= msed_pkg::ChCr)) begin
				if (!st_seen) begin
					st_pend = 1'b1;
					st_seen = 1'b1;
				end
			end else begin
				put_visible(c);
			end
		end
	endfunction

	function automatic void take_byte(input logic [ByteW-1:0] c);
		ent_move_t m;
		if (st_prog == msed_pkg::ProgNone || st_prog == msed_pkg::ProgBad) begin
			st_prog = msed_pkg::ProgNone;
			plain_byte(c);
			return;
		end
		m = entity_move(st_prog, c);
		if (m.dst == msed_pkg::ProgBad) begin
			// broken entity: replay the prefix, then treat the byte afresh
			flush_held();
			plain_byte(c);
		end else if (m.dec != msed_pkg::ChNul) begin
			st_prog = msed_pkg::ProgNone;
			put_visible(m.dec);
		end else begin
			st_prog = m.dst;
		end
	endfunction

	// queue the result words one accepted input word owes
	function automatic void predict_clean(input logic [ByteW-1:0] c, input logic last);
		clean_word_t r;
		int          n;
		rel_q.delete();
		take_byte(c);
		if (last) flush_held();   // pending space goes out only before a flushed prefix, else it is dropped
		n = rel_q.size();
		if (last && n == 0) begin
			r = '{out_ch: msed_pkg::ChNul, has_ch: 1'b0, run_end: 1'b1, str_end: 1'b1};
			cleaned_q.push_back(r);
		end
		for (int k = 0; k < n; k++) begin
			r.out_ch  = rel_q[k];
			r.has_ch  = 1'b1;
			r.run_end = (k == n - 1);
			r.str_end = last && (k == n - 1);
			cleaned_q.push_back(r);
		end
		if (last) reset_parser();
	endfunction

	function automatic void check_clean();
		clean_word_t e;
		if (cleaned_q.size() == 0) begin
			$error("result word with nothing predicted: out_byte %02h has_byte %0b",
			       out_byte, has_byte);
			err_cnt++;
			return;
		end
		e = cleaned_q.pop_front();
		if (out_byte !== e.out_ch) begin
			$error("out_byte: expected %02h, actual %02h", e.out_ch, out_byte);
			err_cnt++;
		end
		if (has_byte !== e.has_ch) begin
			$error("has_byte: expected %0b, actual %0b", e.has_ch, has_byte);
			err_cnt++;
		end
		if (run_last !== e.run_end) begin
			$error("run_last: expected %0b, actual %0b", e.run_end, run_last);
			err_cnt++;
		end
		if (string_end !== e.str_end) begin
			$error("string_end: expected %0b, actual %0b", e.str_end, string_end);
			err_cnt++;
		end
		results_ok++;
		if (e.str_end) strings_end++;
		if (!e.has_ch) bare_marks++;
	endfunction

	// Both handshakes are sampled here, at the edge where they complete.
	// Prediction comes before the check so the order inside one edge is fixed.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predict_clean(in_byte, in_last);
				words_in++;
			end
			if (out_valid && !out_stall) check_clean();
		end
	end

	// ------------------------------------------------------------------
	// receiver: random stall, or a long hold when a test asks for one
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_cnt != 0) begin
			out_stall <= 1'b1;
			hold_cnt = hold_cnt - 1;
		end else if (hold_served != hold_reqs) begin
			hold_served = hold_reqs;
			hold_cnt    = HoldCycles - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	// ------------------------------------------------------------------
	// sender
	// ------------------------------------------------------------------
	// Called at a rising edge; returns at the edge where the word is taken,
	// leaving valid high so a following word can go out back to back.
	task automatic send_word(input logic [7:0] b, input logic l);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		in_last  <= l;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		words_sent++;
	endtask

	task automatic send_literal(input string s, input logic ends);
		for (int i = 0; i < s.len(); i++) send_word(s[i], ends && (i == s.len() - 1));
	endtask

	task automatic send_text();
		foreach (text_q[i]) send_word(text_q[i], i == text_q.size() - 1);
	endtask

	task automatic pause_until_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (cleaned_q.size() != 0) @(posedge clk);
	endtask

	function automatic string ent_name(input int k);
		case (k)
			0:       return "&amp;";
			1:       return "&quot;";
			2:       return "&#39;";
			default: return "&apos;";
		endcase
	endfunction

	// Mostly well-formed markup: words, blank runs, entities, tags; a share
	// of broken entities, unclosed tags, stray '>' and raw bytes.
	task automatic build_markup_string();
		int         n_tok;
		int         kind;
		int         cut;
		string      e;
		logic [7:0] b;
		text_q.delete();
		if ($urandom_range(99) < 8) begin
			repeat ($urandom_range(8, 1)) text_q.push_back(8'($urandom_range(255, 1)));
			return;
		end
		n_tok = ($urandom_range(9) == 0) ? $urandom_range(12, 6) : $urandom_range(5, 1);
		repeat (n_tok) begin
			kind = $urandom_range(99);
			if (kind < 28) begin
				repeat ($urandom_range(5, 1)) begin
					b = ($urandom_range(2) == 0) ? 8'($urandom_range(8'h7e, 8'h21))
					                             : 8'($urandom_range(8'h7a, 8'h61));
					text_q.push_back(b);
				end
			end else if (kind < 42) begin
				repeat ($urandom_range(3, 1)) begin
					b = 8'($urandom_range(13, 8));
					if (b == 8'd8) b = msed_pkg::ChSpace;
					text_q.push_back(b);
				end
			end else if (kind < 62) begin
				e = ent_name($urandom_range(3));
				for (int i = 0; i < e.len(); i++) text_q.push_back(e[i]);
			end else if (kind < 74) begin
				// prefix of an entity, from '&' alone up to all but the ';'
				e   = ent_name($urandom_range(3));
				cut = $urandom_range(e.len() - 2, 0);
				for (int i = 0; i <= cut; i++) text_q.push_back(e[i]);
				if ($urandom_range(3) != 0) text_q.push_back(8'($urandom_range(255, 1)));
			end else if (kind < 86) begin
				text_q.push_back(msed_pkg::ChLt);
				repeat ($urandom_range(4, 0)) text_q.push_back(8'($urandom_range(255, 1)));
				if ($urandom_range(99) < 85) text_q.push_back(msed_pkg::ChGt);
			end else if (kind < 91) begin
				text_q.push_back(msed_pkg::ChGt);
			end else begin
				text_q.push_back(8'($urandom_range(255, 1)));
			end
		end
	endtask

	task automatic send_random_strings(input int n);
		int start;
		start = words_sent;
		while (words_sent - start < n) begin
			build_markup_string();
			send_text();
		end
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------
	// all four entities are sent; three complete, and the second string ends on a held prefix
	task automatic test_entity_decode();
		send_literal("&amp;&quot;", 1'b1);
		send_literal("&apos;&#39", 1'b1);
	endtask

	// leading blank, top byte value, tag, stray '>', a single blank, and a
	// broken entity that replays after the owed space
	task automatic test_markup_and_spacing();
		send_word(msed_pkg::ChTab, 1'b0);
		send_word(8'hff, 1'b0);
		send_literal("<a>> &q", 1'b0);
		send_word(8'h01, 1'b1);
	endtask

	// a string that releases nothing ends with a bare end marker
	task automatic test_empty_string();
		send_word(msed_pkg::ChSpace, 1'b1);
	endtask

	task automatic test_random_markup();
		send_random_strings(215);
	endtask

	task automatic test_full_rate();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		send_random_strings(60);
		tx_idle_pct = IdlePct;
		rx_idle_pct = IdlePct;
	endtask

	// output held for a long stretch while input is offered at full rate
	task automatic test_backpressure();
		tx_idle_pct = 0;
		hold_reqs++;
		send_random_strings(40);
		tx_idle_pct = IdlePct;
	endtask

	task automatic test_drain_pauses();
		repeat (4) begin
			send_random_strings(15);
			pause_until_drained();
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_entity_decode();
		test_markup_and_spacing();
		test_empty_string();
		test_random_markup();
		test_full_rate();
		test_backpressure();
		test_drain_pauses();

		pause_until_drained();
		repeat (TailCycles) @(posedge clk);

		$display("Covered %0d input words in %0d strings: %0d result words checked,",
		         words_in, strings_end, results_ok);
		$display("%0d bare end markers, random idling, full rate, a %0d-cycle hold, drains.",
		         bare_marks, HoldCycles);
		if (err_cnt == 0) begin
			$display("markup_strip_entity_decode_unit verification clean");
		end else begin
			$display("markup_strip_entity_decode_unit verification failed");
		end
		$finish;
	end

	initial begin
		#(TimeoutNs);
		$display("markup_strip_entity_decode_unit verification failed");
		$finish;
	end

endmodule

// ----- files.f -----
sv/msed_pkg.sv
sv/markup_strip_entity_decode_unit.sv
verif/tb_top.sv
